/* hdl/kwrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwrs_pkg
// Shared widths, constants, register indexes and types for the kernel
// weighted row sum block.
// ----------------------------------------------------------------------------
package kwrs_pkg;

    localparam int DIST_W        = 16;
    localparam int WEIGHT_W      = 17;
    localparam int ACC_W         = 48;
    localparam int TADDR_W       = 10;   // table_addr / last_table_index field
    localparam int STEP_W        = 8;
    localparam int ABUND_FIELD_W = 20;
    localparam int IN_DATA_W     = 64;
    localparam int IN_USER_W     = 2;
    localparam int OUT_DATA_W    = 56;
    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 64;

    localparam int TABLE_DEPTH_DEF    = 1024;
    localparam int ABUNDANCE_BITS_DEF = 20;

    localparam logic [WEIGHT_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [DIST_W-1:0]   DIST_MAX = 16'hFFFF;
    localparam logic [ACC_W-1:0]    ACC_MAX  = {ACC_W{1'b1}};

    // register indexes (byte address / 8)
    localparam logic [1:0] REG_STEP  = 2'd0;
    localparam logic [1:0] REG_LAST  = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;

    localparam logic [STEP_W-1:0]  STEP_RST  = 8'd1;
    localparam logic [TADDR_W-1:0] LAST_RST  = '0;
    localparam logic [ACC_W-1:0]   SCALE_RST = '0;

    localparam logic OP_TABLE_WR = 1'b0;
    localparam logic OP_ELEMENT  = 1'b1;

    typedef struct packed {
        logic [STEP_W-1:0]  step;
        logic [TADDR_W-1:0] last_idx;
        logic [ACC_W-1:0]   scale;
    } t_cfg;

    // handshake between the accumulator stage and the row probability unit
    typedef struct packed {
        logic start;
        logic ack;
    } t_prob_ctl;

endpackage

/* hdl/kwrs_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwrs_cfg
// APB register file: distance step, last table index and sum scale.
// ----------------------------------------------------------------------------
module kwrs_cfg
    import kwrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [STEP_W-1:0]  r_step;
    logic [TADDR_W-1:0] r_last;
    logic [ACC_W-1:0]   r_scale;
    logic [1:0]         w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:3];
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_RST;
            r_last  <= LAST_RST;
            r_scale <= SCALE_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_STEP:  r_step  <= pwdata[STEP_W-1:0];
                REG_LAST:  r_last  <= pwdata[TADDR_W-1:0];
                REG_SCALE: r_scale <= pwdata[ACC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_STEP:  prdata = {{(APB_DATA_W-STEP_W){1'b0}}, r_step};
            REG_LAST:  prdata = {{(APB_DATA_W-TADDR_W){1'b0}}, r_last};
            REG_SCALE: prdata = {{(APB_DATA_W-ACC_W){1'b0}}, r_scale};
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.step     = r_step;
    assign o_cfg.last_idx = r_last;
    assign o_cfg.scale    = r_scale;

endmodule

/* hdl/kwrs_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwrs_table
// Kernel weight memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kwrs_table
    import kwrs_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)(
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic [WEIGHT_W-1:0] i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output logic [WEIGHT_W-1:0] o_rdata
);

    logic [WEIGHT_W-1:0] r_mem [DEPTH];
    logic [WEIGHT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/kwrs_prob.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwrs_prob
// Row probability: 65536 - floor(scale * acc / 2^48), floored at zero.
// The 48x48 product is built from four 24x24 partial products.
// ----------------------------------------------------------------------------
module kwrs_prob
    import kwrs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_prob_ctl           i_ctl,
    input  logic [ACC_W-1:0]    i_scale,
    input  logic [ACC_W-1:0]    i_acc,
    output logic                o_done,
    output logic [WEIGHT_W-1:0] o_prob
);

    localparam int HALF_W = ACC_W / 2;
    localparam int PROD_W = 2 * HALF_W;
    localparam int SUM_W  = 2 * ACC_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [2:0] LAST_STEP = 3'd4;

    logic [1:0]        r_state;
    logic [2:0]        r_step;
    logic [ACC_W-1:0]  r_scale;
    logic [ACC_W-1:0]  r_acc;
    logic [PROD_W-1:0] r_prod;
    logic [1:0]        r_pshift;
    logic [SUM_W-1:0]  r_sum;

    logic [HALF_W-1:0] w_a;
    logic [HALF_W-1:0] w_s;
    logic [SUM_W-1:0]  w_addend;

    assign w_a = r_step[0] ? r_acc[ACC_W-1:HALF_W]   : r_acc[HALF_W-1:0];
    assign w_s = r_step[1] ? r_scale[ACC_W-1:HALF_W] : r_scale[HALF_W-1:0];

    always_comb begin
        case (r_pshift)
            2'd0:    w_addend = {{(SUM_W-PROD_W){1'b0}}, r_prod};
            2'd1:    w_addend = {{(SUM_W-PROD_W-HALF_W){1'b0}}, r_prod, {HALF_W{1'b0}}};
            2'd2:    w_addend = {r_prod, {ACC_W{1'b0}}};
            default: w_addend = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_ctl.start) begin
                        r_state <= ST_RUN;
                        r_step  <= '0;
                    end
                end
                ST_RUN: begin
                    if (r_step == LAST_STEP) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                ST_DONE: begin
                    if (i_ctl.ack) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath: product registered, added one step later
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_ctl.start) begin
            r_scale <= i_scale;
            r_acc   <= i_acc;
            r_sum   <= '0;
        end else if (r_state == ST_RUN) begin
            if (r_step != LAST_STEP) begin
                r_prod   <= w_a * w_s;
                r_pshift <= {1'b0, r_step[0]} + {1'b0, r_step[1]};
            end
            if (r_step != 3'd0) begin
                r_sum <= r_sum + w_addend;
            end
        end
    end

    assign o_done = (r_state == ST_DONE);
    assign o_prob = (r_sum[SUM_W-1:64] != '0) ? '0
                  : ONE_Q16 - {1'b0, r_sum[63:ACC_W]};

endmodule

/* hdl/kernel_weighted_row_sum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kernel_weighted_row_sum
// Streams a distance matrix row: bumps distances, looks up kernel weights,
// accumulates abundance * weight and emits the clamped row probability.
// Element words pass through the table read stage, the weight and product
// stage and the output register. Throughput: one word per cycle while the
// output is free and no row product is running; a row end holds the input
// while the 48x48 scale product runs through one 24x24 multiplier.
// Table writes produce no output word. Reset clears the pipeline, accumulator
// and registers; the table is not cleared, entries are defined once written.
// ----------------------------------------------------------------------------
module kernel_weighted_row_sum
    import kwrs_pkg::*;
#(
    parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
    parameter int ABUNDANCE_BITS = ABUNDANCE_BITS_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // table_addr[9:0], table_value[26:10], dist_in[42:27], abundance[62:43], zero[63]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[0], is_self[1]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    // row_end
    input  logic                  s_axis_tlast,
    // output words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // dist_out[15:0], weight_out[32:16], prob[49:33], zero[55:50]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // row_done
    output logic                  m_axis_tlast
);

    localparam int MEM_DEPTH = (TABLE_DEPTH < (1 << TADDR_W)) ? TABLE_DEPTH : (1 << TADDR_W);
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int AB_W      = (ABUNDANCE_BITS < ABUND_FIELD_W) ? ABUNDANCE_BITS
                                                                 : ABUND_FIELD_W;
    localparam int TERM_W    = AB_W + WEIGHT_W;
    localparam logic [DIST_W-1:0] IDX_MAX = DIST_W'(MEM_DEPTH - 1);

    t_cfg      w_cfg;
    t_prob_ctl w_pctl;

    // input field unpacking
    logic [TADDR_W-1:0]       w_taddr;
    logic [WEIGHT_W-1:0]      w_tval;
    logic [DIST_W-1:0]        w_din;
    logic [ABUND_FIELD_W-1:0] w_abund;
    logic                     w_op;
    logic                     w_self;

    assign w_taddr = s_axis_tdata[9:0];
    assign w_tval  = s_axis_tdata[26:10];
    assign w_din   = s_axis_tdata[42:27];
    assign w_abund = s_axis_tdata[62:43];
    assign w_op    = s_axis_tuser[0];
    assign w_self  = s_axis_tuser[1];

    logic w_adv;
    logic w_out_free;
    logic w_acc_in;

    // stage 1: table read in flight
    logic              r_s1_valid;
    logic              r_s1_self;
    logic              r_s1_end;
    logic [DIST_W-1:0] r_s1_dist;
    logic [AB_W-1:0]   r_s1_ab;

    // stage 2: weight and product
    logic                r_s2_valid;
    logic                r_s2_self;
    logic                r_s2_end;
    logic [DIST_W-1:0]   r_s2_dist;
    logic [WEIGHT_W-1:0] r_s2_weight;
    logic [TERM_W-1:0]   r_s2_term;

    logic [ACC_W-1:0]    r_acc;
    logic                r_busy;
    logic [DIST_W-1:0]   r_pend_dist;
    logic [WEIGHT_W-1:0] r_pend_weight;

    logic                r_out_valid;
    logic [DIST_W-1:0]   r_out_dist;
    logic [WEIGHT_W-1:0] r_out_weight;
    logic [WEIGHT_W-1:0] r_out_prob;
    logic                r_out_last;

    logic [DIST_W:0]     w_dsum;
    logic [DIST_W-1:0]   w_dsat;
    logic [DIST_W-1:0]   w_idx_a;
    logic [DIST_W-1:0]   w_idx;
    logic                w_twr;
    logic [WEIGHT_W-1:0] w_tval_sat;
    logic [WEIGHT_W-1:0] w_rdata;
    logic [WEIGHT_W-1:0] w_s1_weight;
    logic [ACC_W:0]      w_acc_sum;
    logic [ACC_W-1:0]    w_acc_next;
    logic                w_pdone;
    logic [WEIGHT_W-1:0] w_prob;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = w_out_free && !r_busy;
    assign s_axis_tready = w_adv;
    assign w_acc_in      = w_adv && s_axis_tvalid;

    // distance bump and table index clamp
    assign w_dsum  = {1'b0, w_din} + {{(DIST_W+1-STEP_W){1'b0}}, w_cfg.step};
    assign w_dsat  = w_dsum[DIST_W] ? DIST_MAX : w_dsum[DIST_W-1:0];
    assign w_idx_a = (w_dsat > {{(DIST_W-TADDR_W){1'b0}}, w_cfg.last_idx})
                   ? {{(DIST_W-TADDR_W){1'b0}}, w_cfg.last_idx} : w_dsat;
    assign w_idx   = (w_idx_a > IDX_MAX) ? IDX_MAX : w_idx_a;

    assign w_twr      = w_acc_in && (w_op == OP_TABLE_WR)
                     && ({{(32-TADDR_W){1'b0}}, w_taddr} < 32'(TABLE_DEPTH));
    assign w_tval_sat = (w_tval > ONE_Q16) ? ONE_Q16 : w_tval;

    kwrs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // a write always lands before any later lookup reads it
    kwrs_table #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_twr),
        .i_waddr (w_taddr[AW-1:0]),
        .i_wdata (w_tval_sat),
        .i_re    (w_adv),
        .i_raddr (w_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_acc_in && (w_op == OP_ELEMENT);
            r_s2_valid <= r_s1_valid;
        end
    end

    assign w_s1_weight = r_s1_self ? ONE_Q16 : w_rdata;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_self   <= w_self;
            r_s1_end    <= s_axis_tlast;
            r_s1_dist   <= w_self ? '0 : w_dsat;
            r_s1_ab     <= w_abund[AB_W-1:0];
            r_s2_self   <= r_s1_self;
            r_s2_end    <= r_s1_end;
            r_s2_dist   <= r_s1_dist;
            r_s2_weight <= w_s1_weight;
            r_s2_term   <= r_s1_ab * w_s1_weight;
        end
    end

    // saturating accumulate
    assign w_acc_sum  = {1'b0, r_acc} + {{(ACC_W+1-TERM_W){1'b0}}, r_s2_term};
    assign w_acc_next = r_s2_self ? r_acc
                      : (w_acc_sum[ACC_W] ? ACC_MAX : w_acc_sum[ACC_W-1:0]);

    assign w_pctl.start = w_adv && r_s2_valid && r_s2_end;
    assign w_pctl.ack   = r_busy && w_pdone && w_out_free;

    kwrs_prob u_prob (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_pctl),
        .i_scale (w_cfg.scale),
        .i_acc   (w_acc_next),
        .o_done  (w_pdone),
        .o_prob  (w_prob)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_busy <= 1'b0;
        end else if (w_pctl.start) begin
            r_acc  <= '0;
            r_busy <= 1'b1;
        end else begin
            if (w_adv && r_s2_valid) begin
                r_acc <= w_acc_next;
            end
            if (w_pctl.ack) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pctl.start) begin
            r_pend_dist   <= r_s2_dist;
            r_pend_weight <= r_s2_weight;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pctl.ack) begin
            r_out_valid <= 1'b1;
        end else if (w_adv && r_s2_valid && !r_s2_end) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pctl.ack) begin
            r_out_dist   <= r_pend_dist;
            r_out_weight <= r_pend_weight;
            r_out_prob   <= w_prob;
            r_out_last   <= 1'b1;
        end else if (w_adv && r_s2_valid && !r_s2_end) begin
            r_out_dist   <= r_s2_dist;
            r_out_weight <= r_s2_weight;
            r_out_prob   <= '0;
            r_out_last   <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-DIST_W-2*WEIGHT_W){1'b0}},
                            r_out_prob, r_out_weight, r_out_dist};
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------------
    a_done_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pdone |-> r_busy)
        else $error("row product finished with no row pending");

    a_row_clears_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pctl.start |=> (r_acc == '0 && r_busy))
        else $error("accumulator not cleared at row end");

    a_self_no_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s2_valid && r_s2_self && !r_s2_end) |=> $stable(r_acc))
        else $error("diagonal element changed the accumulator");

    a_row_word_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pctl.ack |=> (m_axis_tvalid && m_axis_tlast))
        else $error("row result not presented with row_done");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for kernel_weighted_row_sum. Words go in on the input
// stream, a scoreboard predicts the output words from its own copy of the
// weight table, accumulator and registers, and compares every output word in
// order. Runs a directed opener, then random rows under several register
// settings with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import kwrs_pkg::*;

    typedef struct {
        logic                  op;
        logic [TADDR_W-1:0]    taddr;
        logic [WEIGHT_W-1:0]   tval;
        logic [DIST_W-1:0]     dist_in;
        logic [ABUND_FIELD_W-1:0] abund;
        logic                  is_self;
        logic                  row_end;
    } t_elem_word;

    typedef struct {
        logic [DIST_W-1:0]   dist_out;
        logic [WEIGHT_W-1:0] weight;
        logic [WEIGHT_W-1:0] prob;
        logic                row_done;
    } t_row_result;

    class t_scoreboard;
        logic [WEIGHT_W-1:0] weights [TABLE_DEPTH_DEF];   // X until written
        logic [ACC_W-1:0]    row_acc;
        logic [STEP_W-1:0]   step;
        logic [TADDR_W-1:0]  last_idx;
        logic [ACC_W-1:0]    scale;
        t_row_result         expected_results [$];
        int                  errors;

        function new();
            row_acc  = '0;
            step     = STEP_RST;
            last_idx = LAST_RST;
            scale    = SCALE_RST;
            errors   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                REG_STEP:  step = val[STEP_W-1:0];
                REG_LAST:  last_idx = val[TADDR_W-1:0];
                REG_SCALE: scale = val[ACC_W-1:0];
                default: ;
            endcase
        endfunction

        // distance plus step, saturating
        function logic [DIST_W-1:0] bump(logic [DIST_W-1:0] dist_val);
            logic [DIST_W:0] d;
            d = {1'b0, dist_val} + {{(DIST_W+1-STEP_W){1'b0}}, step};
            return d[DIST_W] ? DIST_MAX : d[DIST_W-1:0];
        endfunction

        function int index_for(logic [DIST_W-1:0] dist_val);
            logic [DIST_W-1:0] d;
            logic [DIST_W-1:0] lim;
            d   = bump(dist_val);
            lim = {{(DIST_W-TADDR_W){1'b0}}, last_idx};
            if (d > lim) d = lim;
            return int'(d);
        endfunction

        // 1 - scale*sum in Q1.16, product truncated, clamped at zero
        function logic [WEIGHT_W-1:0] row_prob();
            logic [95:0] p;
            p = 96'(scale) * 96'(row_acc);
            if (p[95:64] != '0) return '0;
            return ONE_Q16 - {1'b0, p[63:48]};
        endfunction

        function void note_word(t_elem_word w);
            t_row_result e;
            logic [WEIGHT_W-1:0] v;
            logic [63:0] term;
            if (w.op == OP_TABLE_WR) begin
                v = (w.tval > ONE_Q16) ? ONE_Q16 : w.tval;
                weights[w.taddr] = v;
                return;
            end
            if (w.is_self) begin
                e.dist_out = '0;
                e.weight   = ONE_Q16;
            end else begin
                e.dist_out = bump(w.dist_in);
                e.weight   = weights[index_for(w.dist_in)];
                term = 64'(w.abund) * 64'(e.weight);
                if (term > 64'(ACC_MAX) - 64'(row_acc)) row_acc = ACC_MAX;
                else row_acc = row_acc + term[ACC_W-1:0];
            end
            if (w.row_end) begin
                e.prob     = row_prob();
                e.row_done = 1'b1;
                row_acc    = '0;
            end else begin
                e.prob     = '0;
                e.row_done = 1'b0;
            end
            expected_results = {expected_results, e};
        endfunction

        function void check_word(logic [OUT_DATA_W-1:0] data, logic last);
            t_row_result e;
            if (expected_results.size() == 0) begin
                $error("output word with nothing expected: data %h last %b", data, last);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (data[15:0] !== e.dist_out) begin
                $error("dist_out: expected %0d, got %0d", e.dist_out, data[15:0]);
                errors++;
            end
            if (data[32:16] !== e.weight) begin
                $error("weight_out: expected %0d, got %0d", e.weight, data[32:16]);
                errors++;
            end
            if (data[49:33] !== e.prob) begin
                $error("prob: expected %0d, got %0d", e.prob, data[49:33]);
                errors++;
            end
            if (last !== e.row_done) begin
                $error("row_done: expected %0d, got %0d", e.row_done, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    t_scoreboard sb = new();

    int source_odds = 0;    // 0: sender never idles
    int sink_odds   = 0;    // 0: receiver never stalls
    int hold_len    = 0;    // long receiver hold-off request
    int words_sent  = 0;

    kernel_weighted_row_sum dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tlast);
    end

    // receiver: random stall bursts plus one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end else if (sink_odds != 0 && $urandom_range(0, sink_odds) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic t_elem_word random_word();
        t_elem_word w;
        w.op      = 1'($urandom_range(0, 1));
        w.taddr   = TADDR_W'($urandom);
        w.tval    = WEIGHT_W'($urandom);
        w.dist_in = DIST_W'($urandom);
        w.abund   = ABUND_FIELD_W'($urandom);
        w.is_self = 1'($urandom_range(0, 1));
        w.row_end = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return ONE_Q16;
            1: return WEIGHT_W'($urandom_range(65537, 131071));
            2: return '0;
            default: return WEIGHT_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [DIST_W-1:0] rand_dist();
        case ($urandom_range(0, 3))
            0: return DIST_W'($urandom);
            1: return DIST_MAX - DIST_W'($urandom_range(0, 300));
            2: return DIST_W'($urandom_range(0, 1100));
            default: return DIST_W'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [ABUND_FIELD_W-1:0] rand_abund();
        case ($urandom_range(0, 3))
            0: return ABUND_FIELD_W'($urandom);
            1: return '1;
            2: return '0;
            default: return ABUND_FIELD_W'($urandom_range(0, 1000));
        endcase
    endfunction

    function automatic logic [ACC_W-1:0] rand_scale();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return ACC_W'(r >> (64 - $urandom_range(18, 34)));
    endfunction

    task automatic push_word(t_elem_word w);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, w.abund, w.dist_in, w.tval, w.taddr};
        s_axis_tuser  <= {w.is_self, w.op};
        s_axis_tlast  <= w.row_end;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(w);
        words_sent++;
        if (source_odds != 0 && $urandom_range(0, source_odds) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic send_table(int addr, logic [WEIGHT_W-1:0] val);
        t_elem_word w;
        w = random_word();
        w.op    = OP_TABLE_WR;
        w.taddr = TADDR_W'(addr);
        w.tval  = val;
        push_word(w);
    endtask

    // writes the entry the lookup will hit first if it was never written
    task automatic send_element(logic [DIST_W-1:0] dist_val, logic [ABUND_FIELD_W-1:0] abund,
                                logic self_flag, logic last_flag);
        t_elem_word w;
        int idx;
        if (!self_flag) begin
            idx = sb.index_for(dist_val);
            if ($isunknown(sb.weights[idx])) send_table(idx, rand_weight());
        end
        w = random_word();
        w.op      = OP_ELEMENT;
        w.dist_in = dist_val;
        w.abund   = abund;
        w.is_self = self_flag;
        w.row_end = last_flag;
        push_word(w);
    endtask

    // table writes give no output word, so allow for the row-end pass too
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // write, then read back in the following transfer
    task automatic reg_write(logic [1:0] idx, logic [63:0] val);
        logic [63:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_STEP:  want = 64'(sb.step);
            REG_LAST:  want = 64'(sb.last_idx);
            default:   want = 64'(sb.scale);
        endcase
        if (prdata !== want) begin
            $error("register %0d readback: expected %h, got %h", idx, want, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(logic [STEP_W-1:0] step, logic [TADDR_W-1:0] last_idx,
                              logic [ACC_W-1:0] scale);
        drain();
        reg_write(REG_STEP, 64'(step));
        reg_write(REG_LAST, 64'(last_idx));
        reg_write(REG_SCALE, 64'(scale));
    endtask

    initial begin
        int kind;
        int len;
        int self_pos;
        int phase_end;
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: step 1, every lookup clamps to entry 0, scale 0
        send_table(0, 17'h1FFFF);                       // stored as 1.0
        send_element(16'hFFFF, 20'hFFFFF, 1'b0, 1'b0);  // distance saturates
        send_element(16'h0000, 20'h00000, 1'b0, 1'b0);
        send_element(16'hFFFE, 20'h00001, 1'b1, 1'b1);  // diagonal ends the row

        set_config(8'hFF, 10'd1023, ACC_MAX);
        send_table(1023, '0);
        send_table(512, ONE_Q16);
        send_table(0, 17'h10001);
        send_element(16'h0000, 20'hFFFFF, 1'b0, 1'b0);
        send_element(16'hFF00, 20'hFFFFF, 1'b0, 1'b0);  // clamps to last entry
        send_element(16'h0101, 20'h12345, 1'b0, 1'b0);
        send_element(16'h0000, 20'hFFFFF, 1'b1, 1'b0);
        send_element(16'd100, 20'hABCDE, 1'b0, 1'b1);   // huge product: prob 0
        send_element(16'hFFFF, 20'hFFFFF, 1'b1, 1'b1);  // empty sum: prob 1.0

        set_config(8'h00, 10'd1023, 48'h1_0000_0000);
        send_element(16'd255, 20'hFFFFF, 1'b0, 1'b0);
        send_element(16'd0, 20'h54321, 1'b0, 1'b0);
        send_element(16'd1023, 20'h0F0F0, 1'b0, 1'b1);

        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(0, 2))
                0: source_odds = 0;
                1: source_odds = 3;
                default: source_odds = 10;
            endcase
            case ($urandom_range(0, 2))
                0: sink_odds = 0;
                1: sink_odds = 3;
                default: sink_odds = 10;
            endcase
            case (p)
                0: set_config(8'h00, 10'd1023, '0);
                1: set_config(8'hFF, 10'd0, ACC_MAX);
                2: set_config(STEP_W'($urandom), 10'd1023, rand_scale());
                3: set_config(8'h01, 10'd7, rand_scale());
                4: set_config(STEP_W'($urandom), TADDR_W'($urandom),
                              ACC_W'({$urandom, $urandom}));
                5: set_config(8'hFF, 10'd1023, rand_scale());
                6: set_config(STEP_W'($urandom), 10'd31, rand_scale());
                default: begin
                    source_odds = 0;
                    sink_odds   = 0;
                    set_config(STEP_W'($urandom), TADDR_W'($urandom), rand_scale());
                end
            endcase
            if (p == 3) begin
                source_odds = 0;
                hold_len    = 300;   // output backs up, input must stall
            end
            phase_end = words_sent + 170;
            while (words_sent < phase_end) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    send_table($urandom_range(0, 1023), rand_weight());
                end else begin
                    len      = $urandom_range(1, 12);
                    self_pos = (kind == 1) ? -1 : $urandom_range(0, len - 1);
                    for (int k = 0; k < len; k++)
                        send_element(rand_dist(), rand_abund(),
                                     k == self_pos || (kind == 2 && $urandom_range(0, 3) == 0),
                                     kind != 3 && k == len - 1);
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
